/* hw/rtl/pli_pkg.sv */
`timescale 1ns / 1ps

package pli_pkg;

    localparam int NODES_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_EVAL   = 2'd2,
        KIND_NONE   = 2'd3
    } pli_kind_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_LOW     = 3'd1,
        STS_HIGH    = 3'd2,
        STS_SHORT   = 3'd3,
        STS_FULL    = 3'd4
    } pli_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_DONE
    } pli_state_t;

    typedef struct packed {
        logic              ins_en;
        logic              at_count;
        logic              valid;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] new_y;
    } pli_cell_ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              gt;
        logic              ge;
    } pli_link_t;

    function automatic logic [DATA_W-1:0] sat_quo(input logic neg, input logic ovf,
                                                 input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] r;
        if (neg) begin
            if (ovf || (q > {1'b1, {(DATA_W-1){1'b0}}}))
                r = {1'b1, {(DATA_W-1){1'b0}}};
            else
                r = ~q + 1'b1;
        end
        else begin
            if (ovf || q[DATA_W-1])
                r = {1'b0, {(DATA_W-1){1'b1}}};
            else
                r = q;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/piecewise_linear_interpolation_table_unit.sv */
`timescale 1ns / 1ps
// Insert, clear and unused kinds: result registered in the cycle after the transaction.
// Interpolating evaluate goes through lookup, prep, multiply, divider start,
// then 32 steps of the restoring dividers for value and slope side by side, then done.
// Clamped or short-table evaluate goes from lookup straight to done. One item at a time:
// 1 item per cycle for insert/clear while the output is not stalled.
// Reset empties the table (node count zero); node storage itself is not cleared.
module piecewise_linear_interpolation_table_unit #(
    parameter int NODES     = pli_pkg::NODES_DEF,
    parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key_x[31:0], value_y[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // interp_value[31:0], slope[63:32], status[66:64], zero pad
);

    localparam int CW   = $clog2(NODES + 1);
    localparam int W    = pli_pkg::DATA_W;
    localparam int DW_S = W + FRAC_BITS;

    pli_pkg::pli_state_t     state_reg;
    pli_pkg::pli_state_t     state_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [W-1:0]            key_reg;
    logic [W-1:0]            cmp_key;
    logic                    accept;
    logic                    ins_en;
    pli_pkg::pli_kind_t      kind;

    pli_pkg::pli_cell_ctrl_t ctrl  [NODES];
    pli_pkg::pli_link_t      prev  [NODES];
    pli_pkg::pli_link_t      link  [NODES];
    logic [NODES-1:0]        hit;

    logic [W-1:0] xi_sel, yi_sel, xm_sel, ym_sel, xl_sel, yl_sel;
    logic [W-1:0] xi_reg, yi_reg, xm_reg, ym_reg;
    logic [W-1:0] mag_reg, dx_reg, t_reg;
    logic         neg_reg;
    logic [2*W-1:0] prod_reg;
    logic [W:0]   dy;
    logic [W:0]   dy_abs;
    logic         clamp;
    logic [W-1:0] clamp_val;
    pli_pkg::pli_status_t clamp_sts;

    logic [W-1:0] val_reg, slp_reg;
    pli_pkg::pli_status_t sts_reg;

    logic         div_start;
    logic [W-1:0] qv, qs;
    logic         ovf_v, ovf_s, busy_v, busy_s;

    logic         out_vld_reg;
    logic [71:0]  out_data_reg;
    logic         load_direct;
    logic         load_done;

    assign kind     = pli_pkg::pli_kind_t'(s_tuser);
    assign s_tready = (state_reg == pli_pkg::S_IDLE) && (!out_vld_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign ins_en   = accept && (kind == pli_pkg::KIND_INSERT) && (count_reg != CW'(NODES));
    assign cmp_key  = (state_reg == pli_pkg::S_IDLE) ? s_tdata[W-1:0] : key_reg;

    genvar g;
    generate
        for (g = 0; g < NODES; g++)
        begin : g_cell
            assign ctrl[g].ins_en   = ins_en;
            assign ctrl[g].at_count = (CW'(g) == count_reg);
            assign ctrl[g].valid    = (CW'(g) < count_reg);
            assign ctrl[g].key      = cmp_key;
            assign ctrl[g].new_y    = s_tdata[2*W-1:W];
            if (g == 0)
            begin : g_head
                assign prev[g] = '0;
            end
            else
            begin : g_link
                assign prev[g] = link[g-1];
            end
            pli_cell u_cell
            (
                .clk  (clk),
                .ctrl (ctrl[g]),
                .prev (prev[g]),
                .link (link[g]),
                .hit  (hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        xi_sel = '0;
        yi_sel = '0;
        xm_sel = '0;
        ym_sel = '0;
        xl_sel = '0;
        yl_sel = '0;
        for (int k = 1; k < NODES; k++)
        begin
            if (hit[k])
            begin
                xi_sel |= link[k].x;
                yi_sel |= link[k].y;
                xm_sel |= link[k-1].x;
                ym_sel |= link[k-1].y;
            end
        end
        for (int k = 0; k < NODES; k++)
        begin
            if (CW'(k + 1) == count_reg)
            begin
                xl_sel |= link[k].x;
                yl_sel |= link[k].y;
            end
        end
    end

    always_comb
    begin
        clamp     = 1'b1;
        clamp_val = '0;
        clamp_sts = pli_pkg::STS_SHORT;
        if (count_reg < CW'(2))
        begin
            clamp_sts = pli_pkg::STS_SHORT;
        end
        else if ($signed(key_reg) <= $signed(link[0].x))
        begin
            clamp_val = link[0].y;
            clamp_sts = pli_pkg::STS_LOW;
        end
        else if ($signed(key_reg) >= $signed(xl_sel))
        begin
            clamp_val = yl_sel;
            clamp_sts = pli_pkg::STS_HIGH;
        end
        else
        begin
            clamp     = 1'b0;
            clamp_sts = pli_pkg::STS_OK;
        end
    end

    assign dy     = {yi_reg[W-1], yi_reg} - {ym_reg[W-1], ym_reg};
    assign dy_abs = dy[W] ? (~dy + 1'b1) : dy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pli_pkg::S_IDLE:
                if (accept && (kind == pli_pkg::KIND_EVAL))
                    state_next = pli_pkg::S_LOOK;
            pli_pkg::S_LOOK:
                state_next = clamp ? pli_pkg::S_DONE : pli_pkg::S_PREP;
            pli_pkg::S_PREP:
                state_next = pli_pkg::S_MUL;
            pli_pkg::S_MUL:
                state_next = pli_pkg::S_DSTART;
            pli_pkg::S_DSTART:
                state_next = pli_pkg::S_DIV;
            pli_pkg::S_DIV:
                if (!busy_v && !busy_s)
                    state_next = pli_pkg::S_DONE;
            pli_pkg::S_DONE:
                if (!out_vld_reg || m_tready)
                    state_next = pli_pkg::S_IDLE;
            default:
                state_next = pli_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        div_start   = (state_reg == pli_pkg::S_DSTART);
        load_direct = accept && (kind != pli_pkg::KIND_EVAL);
        load_done   = (state_reg == pli_pkg::S_DONE) && (!out_vld_reg || m_tready);
        count_next  = count_reg;
        if (accept && (kind == pli_pkg::KIND_CLEAR))
            count_next = '0;
        else if (ins_en)
            count_next = count_reg + 1'b1;
    end

    pli_div #(.DW(2 * W)) u_div_val
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dx_reg),
        .quo      (qv),
        .ovf      (ovf_v),
        .busy     (busy_v)
    );

    pli_div #(.DW(DW_S)) u_div_slp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW_S'(mag_reg) << FRAC_BITS),
        .divisor  (dx_reg),
        .quo      (qs),
        .ovf      (ovf_s),
        .busy     (busy_s)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pli_pkg::S_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_direct || load_done)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            key_reg <= s_tdata[W-1:0];
        if (state_reg == pli_pkg::S_LOOK)
        begin
            xi_reg  <= xi_sel;
            yi_reg  <= yi_sel;
            xm_reg  <= xm_sel;
            ym_reg  <= ym_sel;
            val_reg <= clamp_val;
            slp_reg <= '0;
            sts_reg <= clamp_sts;
        end
        if (state_reg == pli_pkg::S_PREP)
        begin
            neg_reg <= dy[W];
            mag_reg <= dy_abs[W-1:0];
            dx_reg  <= xi_reg - xm_reg;
            t_reg   <= key_reg - xm_reg;
        end
        if (state_reg == pli_pkg::S_MUL)
            prod_reg <= mag_reg * t_reg;
        if ((state_reg == pli_pkg::S_DIV) && !busy_v && !busy_s)
        begin
            val_reg <= ym_reg + pli_pkg::sat_quo(neg_reg, ovf_v, qv);
            slp_reg <= pli_pkg::sat_quo(neg_reg, ovf_s, qs);
            sts_reg <= pli_pkg::STS_OK;
        end
        if (load_direct)
        begin
            if ((kind == pli_pkg::KIND_INSERT) && !ins_en)
                out_data_reg <= {5'd0, pli_pkg::STS_FULL, {(2*W){1'b0}}};
            else
                out_data_reg <= {5'd0, pli_pkg::STS_OK, {(2*W){1'b0}}};
        end
        else if (load_done)
            out_data_reg <= {5'd0, sts_reg, slp_reg, val_reg};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/pli_cell.sv */
`timescale 1ns / 1ps

module pli_cell
(
    input  logic                   clk,
    input  pli_pkg::pli_cell_ctrl_t ctrl,
    input  pli_pkg::pli_link_t     prev,
    output pli_pkg::pli_link_t     link,
    output logic                   hit
);

    logic [pli_pkg::DATA_W-1:0] x_reg;
    logic [pli_pkg::DATA_W-1:0] y_reg;
    logic [pli_pkg::DATA_W-1:0] x_next;
    logic [pli_pkg::DATA_W-1:0] y_next;
    logic                       gt;
    logic                       ge;

    assign gt = ctrl.valid && ($signed(x_reg) > $signed(ctrl.key));
    assign ge = ctrl.valid && ($signed(x_reg) >= $signed(ctrl.key));

    always_comb
    begin
        if (prev.gt)
        begin
            x_next = prev.x;
            y_next = prev.y;
        end
        else if (gt || ctrl.at_count)
        begin
            x_next = ctrl.key;
            y_next = ctrl.new_y;
        end
        else
        begin
            x_next = x_reg;
            y_next = y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign link.x  = x_reg;
    assign link.y  = y_reg;
    assign link.gt = gt;
    assign link.ge = ge;
    assign hit     = ge && !prev.ge;

endmodule

/* hw/rtl/pli_div.sv */
`timescale 1ns / 1ps

module pli_div #(
    parameter int DW = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DW-1:0]              dividend,
    input  logic [pli_pkg::DATA_W-1:0] divisor,
    output logic [pli_pkg::DATA_W-1:0] quo,
    output logic                       ovf,
    output logic                       busy
);

    localparam int QW = pli_pkg::DATA_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] rem_reg;
    logic [QW-1:0] rem_next;
    logic [QW-1:0] sh_reg;
    logic [QW-1:0] sh_next;
    logic          ovf_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [DW-1:0] hi;
    logic [QW:0]   rem2;
    logic [QW:0]   diff;

    assign hi   = dividend >> QW;
    assign rem2 = {rem_reg, sh_reg[QW-1]};
    assign diff = rem2 - {1'b0, divisor};

    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = hi[QW-1:0];
            sh_next  = dividend[QW-1:0];
            cnt_next = CW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[QW])
                rem_next = diff[QW-1:0];
            else
                rem_next = rem2[QW-1:0];
            sh_next  = {sh_reg[QW-2:0], !diff[QW]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (start)
            ovf_reg <= (hi >= DW'(divisor));
    end

    assign quo  = sh_reg;
    assign ovf  = ovf_reg;
    assign busy = (cnt_reg != '0);

endmodule

/* hw/rtl/pli_checker.sv */
`timescale 1ns / 1ps

module pli_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready)
        else $error("input taken while result blocked");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == pli_pkg::KIND_EVAL) |=> !s_tready && !m_tvalid)
        else $error("evaluate did not occupy the block");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != pli_pkg::KIND_EVAL)
        |=> m_tvalid && (m_tdata[63:0] == 64'd0))
        else $error("non-evaluate transaction gave no zero result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[66:64] == pli_pkg::STS_OK) || (m_tdata[66:64] == pli_pkg::STS_LOW)
        || (m_tdata[66:64] == pli_pkg::STS_HIGH) || (m_tdata[66:64] == pli_pkg::STS_SHORT)
        || (m_tdata[66:64] == pli_pkg::STS_FULL))
        else $error("status code out of range");

endmodule

bind piecewise_linear_interpolation_table_unit pli_checker u_pli_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/piecewise_linear_interpolation_table_unit_tb.sv */
`timescale 1ns / 1ps

module piecewise_linear_interpolation_table_unit_tb;

    localparam int NODES      = pli_pkg::NODES_DEF;
    localparam int FRAC       = pli_pkg::FRAC_BITS_DEF;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 60;
    localparam int EXP_DEPTH  = 1024;

    typedef struct {
        logic [31:0]          interp_value;
        logic [31:0]          slope;
        pli_pkg::pli_status_t status;
    } interp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key_x[31:0], value_y[63:32]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // interp_value[31:0], slope[63:32], status[66:64], zero pad

    interp_result_t exp_buf [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    logic signed [31:0] table_x [NODES];
    logic signed [31:0] table_y [NODES];
    int          table_len;
    int          mismatches;
    int          idle_mode;
    int          hold_cycles;
    int          stall_cycles;

    piecewise_linear_interpolation_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sat_quotient(bit neg, longint unsigned q);
        if (neg)
            return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic interp_result_t interpolate(pli_pkg::pli_kind_t kind,
                                                   logic signed [31:0] x,
                                                   logic signed [31:0] y);
        interp_result_t r;
        int pos;
        int i;
        longint dx;
        longint dy;
        longint t;
        longint unsigned mag;
        longint v;
        longint s;
        bit neg;
        r.interp_value = '0;
        r.slope = '0;
        r.status = pli_pkg::STS_OK;
        case (kind)
            pli_pkg::KIND_INSERT:
            begin
                if (table_len >= NODES)
                    r.status = pli_pkg::STS_FULL;
                else
                begin
                    pos = table_len;
                    while (pos > 0 && table_x[pos-1] > x)
                        pos--;
                    for (i = table_len; i > pos; i--)
                    begin
                        table_x[i] = table_x[i-1];
                        table_y[i] = table_y[i-1];
                    end
                    table_x[pos] = x;
                    table_y[pos] = y;
                    table_len++;
                end
            end
            pli_pkg::KIND_CLEAR:
                table_len = 0;
            pli_pkg::KIND_EVAL:
            begin
                if (table_len < 2)
                    r.status = pli_pkg::STS_SHORT;
                else if (x <= table_x[0])
                begin
                    r.interp_value = table_y[0];
                    r.status = pli_pkg::STS_LOW;
                end
                else if (x >= table_x[table_len-1])
                begin
                    r.interp_value = table_y[table_len-1];
                    r.status = pli_pkg::STS_HIGH;
                end
                else
                begin
                    i = 1;
                    while (i < table_len - 1 && x > table_x[i])
                        i++;
                    dx = longint'(table_x[i]) - longint'(table_x[i-1]);
                    dy = longint'(table_y[i]) - longint'(table_y[i-1]);
                    t = longint'(x) - longint'(table_x[i-1]);
                    neg = dy < 0;
                    mag = neg ? longint'(-dy) : dy;
                    v = longint'(table_y[i-1])
                        + sat_quotient(neg, (mag * longint'(t)) / longint'(dx));
                    s = sat_quotient(neg, (mag << FRAC) / longint'(dx));
                    r.interp_value = v[31:0];
                    r.slope = s[31:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    function automatic bit idle_now(bit sender);
        int pct;
        pct = (idle_mode == 0) ? (sender ? 14 : 62) :
              (idle_mode == 1) ? (sender ? 62 : 14) : 0;
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic send_item(pli_pkg::pli_kind_t kind, logic [31:0] x, logic [31:0] y);
        if (idle_now(1'b1))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (idle_now(1'b1))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_buf[exp_wr % EXP_DEPTH] = interpolate(kind, x, y);
        exp_wr++;
    endtask

    always @(posedge clk)
    begin
        interp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_rd == exp_wr)
            begin
                report_mismatch("unexpected transaction", m_tdata[31:0], '0);
            end
            else
            begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tdata[31:0] !== want.interp_value)
                    report_mismatch("interp_value", m_tdata[31:0], want.interp_value);
                if (m_tdata[63:32] !== want.slope)
                    report_mismatch("slope", m_tdata[63:32], want.slope);
                if (m_tdata[66:64] !== want.status)
                    report_mismatch("status", {29'd0, m_tdata[66:64]}, {29'd0, want.status});
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !idle_now(1'b0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9, 0))
            0, 1:    return $urandom;
            2:       return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(32'h0010_0000, 0) - 32'h0008_0000;
        endcase
    endfunction

    task automatic test_short_table();
        send_item(pli_pkg::KIND_EVAL, 32'h0001_0000, 32'hffff_ffff);
        send_item(pli_pkg::KIND_INSERT, 32'h0002_0000, 32'h0003_0000);
        send_item(pli_pkg::KIND_EVAL, 32'h0002_0000, '0);
        send_item(pli_pkg::KIND_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send_item(pli_pkg::KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_item(pli_pkg::KIND_EVAL, '0, '0);
    endtask

    task automatic test_extremes();
        send_item(pli_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(pli_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(pli_pkg::KIND_INSERT, 32'h0000_0000, 32'h0001_0000);
        send_item(pli_pkg::KIND_INSERT, 32'h0000_0000, 32'hffff_0000);
        send_item(pli_pkg::KIND_INSERT, 32'h0000_0001, 32'h7fff_ffff);
        send_item(pli_pkg::KIND_EVAL, 32'h8000_0000, '0);
        send_item(pli_pkg::KIND_EVAL, 32'h7fff_ffff, '0);
        send_item(pli_pkg::KIND_EVAL, 32'hc000_0000, '0);
        send_item(pli_pkg::KIND_EVAL, 32'h4000_0000, '0);
        send_item(pli_pkg::KIND_EVAL, 32'h0000_0000, '0);
        send_item(pli_pkg::KIND_EVAL, 32'h0000_0001, '0);
        send_item(pli_pkg::KIND_EVAL, 32'hffff_ffff, '0);
        send_item(pli_pkg::KIND_INSERT, 32'h0000_0002, 32'h8000_0000);
        send_item(pli_pkg::KIND_EVAL, 32'h0000_0002, '0);
        send_item(pli_pkg::KIND_EVAL, 32'h0000_0003, '0);
        send_item(pli_pkg::KIND_CLEAR, '0, '0);
    endtask

    task automatic test_table_full();
        int k;
        for (k = 0; k < NODES; k++)
            send_item(pli_pkg::KIND_INSERT, pick_key(), $urandom);
        send_item(pli_pkg::KIND_INSERT, 32'h0000_1000, 32'h0000_2000);
        send_item(pli_pkg::KIND_EVAL, pick_key(), '0);
        send_item(pli_pkg::KIND_CLEAR, '0, '0);
    endtask

    task automatic test_random_mix(int count, bit with_hold);
        int k;
        int sel;
        for (k = 0; k < count; k++)
        begin
            if (with_hold && k == count / 3)
                hold_cycles = HOLD_LEN;
            sel = $urandom_range(99, 0);
            if (sel < 3 || (table_len >= NODES && sel < 30))
                send_item(pli_pkg::KIND_CLEAR, $urandom, $urandom);
            else if (sel < 5)
                send_item(pli_pkg::KIND_NONE, $urandom, $urandom);
            else if (sel < 50 || table_len < 2)
                send_item(pli_pkg::KIND_INSERT, pick_key(), $urandom);
            else
                send_item(pli_pkg::KIND_EVAL, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = pli_pkg::KIND_INSERT;
        m_tready = 1'b0;
        exp_wr = 0;
        exp_rd = 0;
        table_len = 0;
        mismatches = 0;
        idle_mode = 0;
        hold_cycles = 0;
        stall_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_table();
        test_extremes();
        test_table_full();
        test_random_mix(105, 1'b1);
        idle_mode = 1;
        test_random_mix(105, 1'b0);
        idle_mode = 2;
        test_random_mix(105, 1'b1);
        s_tvalid <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && exp_rd == exp_wr)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
